>>> src/pfr_pkg.sv
// Shared types and constants of the parameter frame receiver.
// No dependencies; pfr_ifs, pfr_ctrl and param_frame_receiver refer to this package.
`timescale 1ns / 1ps
`default_nettype none

package pfr_pkg;

  localparam int unsigned STORE_LEN = 56;

  localparam logic [7:0] HDR_FIRST  = 8'h55;
  localparam logic [7:0] HDR_SECOND = 8'hAA;

  localparam logic [7:0] CMD_READ  = 8'd1;
  localparam logic [7:0] CMD_START = 8'd2;
  localparam logic [7:0] CMD_ACK   = 8'd3;
  // Closing byte of a frame that asks for the stored words to be written out.
  localparam logic [7:0] FRAME_OK  = 8'd2;

  typedef enum logic [1:0] {
    KIND_READ = 2'd0,
    KIND_BEEP = 2'd1,
    KIND_WORD = 2'd2,
    KIND_DONE = 2'd3
  } kind_t;

  // One result beat handed from the sequencer to the output register.
  typedef struct packed {
    logic       load;
    kind_t      kind;
    logic [3:0] index;
    logic       last;
  } emit_t;

endpackage

`default_nettype wire

>>> src/pfr_ifs.sv
// Valid/ready channel interfaces of the parameter frame receiver.
// Depends on pfr_pkg for the result kind type.
`timescale 1ns / 1ps
`default_nettype none

interface pfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface pfr_out_if;
  logic           valid;
  logic           ready;
  pfr_pkg::kind_t kind;
  logic [3:0]     param_index;
  logic [31:0]    param_word;
  logic           last;

  modport source (output valid, output kind, output param_index, output param_word,
                  output last, input ready);
  modport sink (input valid, input kind, input param_index, input param_word,
                input last, output ready);
endinterface

`default_nettype wire

>>> src/pfr_store.sv
// Payload store: one 32-bit row per parameter word, written a byte lane at a time.
// Self-contained; read data is registered and held while no read is issued.
`timescale 1ns / 1ps
`default_nettype none

module pfr_store #(
  parameter int unsigned ROWS  = 14,
  parameter int unsigned ROW_W = 4
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [ROW_W-1:0] wr_row,
  input  wire logic [1:0]       wr_lane,
  input  wire logic [7:0]       wr_data,
  input  wire logic             rd_en,
  input  wire logic [ROW_W-1:0] rd_row,
  output logic      [31:0]      rd_data_r
);

  logic [31:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row][{wr_lane, 3'b000} +: 8] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_row];
    end
  end

endmodule

`default_nettype wire

>>> src/pfr_ctrl.sv
// Byte handler and result sequencer: header tracking, frame counting and the
// word read-out loop over the payload store. Depends on pfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfr_ctrl #(
  parameter int unsigned PARAM_WORDS = 14,
  parameter int unsigned ROW_W       = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [7:0]       in_byte,
  output logic                  in_ready,
  input  wire logic             out_free,
  output logic                  wr_en,
  output logic      [ROW_W-1:0] wr_row,
  output logic      [1:0]       wr_lane,
  output logic                  rd_en,
  output logic      [ROW_W-1:0] rd_row,
  output pfr_pkg::emit_t        emit
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FETCH = 5'b00010,
    ST_WORD  = 5'b00100,
    ST_DONE  = 5'b01000,
    ST_CMD   = 5'b10000
  } state_t;

  state_t         state_r, state_nxt;
  logic [7:0]     hist0_r, hist1_r;
  logic           receiving_r, receiving_nxt;
  logic [5:0]     count_r, count_nxt;
  logic [3:0]     idx_r, idx_nxt;
  logic           pend_cmd_r, pend_cmd_nxt;
  pfr_pkg::kind_t pend_kind_r, pend_kind_nxt;

  logic       accept;
  logic       hdr_seen;
  logic       frame_end;
  logic       frame_ok;
  logic       cmd_hit;
  logic       last_word;
  logic [3:0] idx_inc;
  logic [3:0] rd_sel;
  logic [3:0] count_row;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign hdr_seen  = (hist1_r == pfr_pkg::HDR_FIRST) && (hist0_r == pfr_pkg::HDR_SECOND);
  assign frame_end = receiving_r && (count_r == 6'(pfr_pkg::STORE_LEN));
  assign frame_ok  = frame_end && (in_byte == pfr_pkg::FRAME_OK);
  assign cmd_hit   = hdr_seen && ((in_byte == pfr_pkg::CMD_READ) ||
                                  (in_byte == pfr_pkg::CMD_START) ||
                                  (in_byte == pfr_pkg::CMD_ACK));
  assign last_word = (idx_r == 4'(PARAM_WORDS - 1));
  assign idx_inc   = idx_r + 4'd1;

  // Bytes beyond the last parameter word are counted but never read, so not kept.
  assign count_row = count_r[5:2];
  assign wr_en     = accept && receiving_r && !frame_end &&
                     (count_r < 6'(PARAM_WORDS * 4));
  assign wr_row    = count_row[ROW_W-1:0];
  assign wr_lane   = count_r[1:0];

  // The next row is fetched while the current word moves into the output register.
  assign rd_en  = (state_r == ST_FETCH) || ((state_r == ST_WORD) && out_free && !last_word);
  assign rd_sel = (state_r == ST_FETCH) ? idx_r : idx_inc;
  assign rd_row = rd_sel[ROW_W-1:0];

  always_comb begin
    receiving_nxt = receiving_r;
    count_nxt     = count_r;
    pend_cmd_nxt  = pend_cmd_r;
    pend_kind_nxt = pend_kind_r;
    idx_nxt       = idx_r;
    state_nxt     = state_r;
    emit          = '0;
    emit.kind     = pfr_pkg::KIND_READ;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (receiving_r) begin
            if (frame_end) begin
              count_nxt     = 6'd0;
              receiving_nxt = 1'b0;
            end else begin
              count_nxt = count_r + 6'd1;
            end
          end
          // A start command restarts the frame even in the middle of one.
          if (hdr_seen && (in_byte == pfr_pkg::CMD_START)) begin
            count_nxt     = 6'd0;
            receiving_nxt = 1'b1;
          end
          pend_cmd_nxt  = cmd_hit;
          pend_kind_nxt = (in_byte == pfr_pkg::CMD_READ) ? pfr_pkg::KIND_READ
                                                         : pfr_pkg::KIND_BEEP;
          idx_nxt       = 4'd0;
          if (frame_ok) begin
            state_nxt = ST_FETCH;
          end else if (cmd_hit) begin
            state_nxt = ST_CMD;
          end
        end
      end
      ST_FETCH: begin
        state_nxt = ST_WORD;
      end
      ST_WORD: begin
        emit.load  = out_free;
        emit.kind  = pfr_pkg::KIND_WORD;
        emit.index = idx_r;
        if (out_free) begin
          if (last_word) begin
            state_nxt = ST_DONE;
          end else begin
            idx_nxt = idx_inc;
          end
        end
      end
      ST_DONE: begin
        emit.load = out_free;
        emit.kind = pfr_pkg::KIND_DONE;
        emit.last = !pend_cmd_r;
        if (out_free) begin
          state_nxt = pend_cmd_r ? ST_CMD : ST_IDLE;
        end
      end
      ST_CMD: begin
        emit.load = out_free;
        emit.kind = pend_kind_r;
        emit.last = 1'b1;
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hist0_r     <= 8'd0;
      hist1_r     <= 8'd0;
      receiving_r <= 1'b0;
      count_r     <= 6'd0;
      pend_cmd_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      receiving_r <= receiving_nxt;
      count_r     <= count_nxt;
      pend_cmd_r  <= pend_cmd_nxt;
      if (accept) begin
        hist1_r <= hist0_r;
        hist0_r <= in_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    pend_kind_r <= pend_kind_nxt;
  end

  a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit.load |-> out_free)
    else $error("result loaded while the output register was still full");

  a_frame_starts_readout: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && frame_ok) |=> (state_r == ST_FETCH))
    else $error("good frame end did not start the word read-out");

  a_count_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !receiving_r |-> (count_r == 6'd0))
    else $error("payload count not zero outside a frame");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 6'(pfr_pkg::STORE_LEN))
    else $error("payload count ran past the store length");

  a_word_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (emit.load && (emit.kind == pfr_pkg::KIND_WORD)) |-> (idx_r < 4'(PARAM_WORDS)))
    else $error("parameter word index out of range");

endmodule

`default_nettype wire

>>> src/param_frame_receiver.sv
// Parameter frame receiver: handles one serial byte per beat. After a 0x55, 0xAA
// header, byte 1 gives a read request, 2 starts a 56-byte frame and beeps, 3 beeps.
// Bytes of a frame go into a store; a closing byte of 2 writes out PARAM_WORDS
// little-endian 32-bit words and a write-done beat, then any command result. A byte
// that causes no result lets the next byte be taken in the following cycle; one
// that causes a result holds the input off until that result is loaded into the
// output register. A good frame end holds the input off through the store fetch,
// the words, the write-done beat and any command result; the single read port of
// the store gives one word per cycle while the output is free. The store needs no
// clearing after reset. Depends on pfr_pkg, pfr_ifs, pfr_store and pfr_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module param_frame_receiver #(
  parameter int unsigned PARAM_WORDS = 14
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pfr_in_if.sink     in_ch,
  pfr_out_if.source  out_ch
);

  localparam int unsigned ROW_W = (PARAM_WORDS > 1) ? $clog2(PARAM_WORDS) : 1;

  pfr_pkg::emit_t emit;
  logic             out_free;
  logic             wr_en;
  logic [ROW_W-1:0] wr_row;
  logic [1:0]       wr_lane;
  logic             rd_en;
  logic [ROW_W-1:0] rd_row;
  logic [31:0]      rd_data_r;

  logic           out_valid_r;
  pfr_pkg::kind_t kind_r;
  logic [3:0]     index_r;
  logic [31:0]    word_r;
  logic           last_r;

  assign out_free = !out_valid_r || out_ch.ready;

  pfr_ctrl #(
    .PARAM_WORDS (PARAM_WORDS),
    .ROW_W       (ROW_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_byte  (in_ch.rx_byte),
    .in_ready (in_ch.ready),
    .out_free (out_free),
    .wr_en    (wr_en),
    .wr_row   (wr_row),
    .wr_lane  (wr_lane),
    .rd_en    (rd_en),
    .rd_row   (rd_row),
    .emit     (emit)
  );

  pfr_store #(
    .ROWS  (PARAM_WORDS),
    .ROW_W (ROW_W)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_row    (wr_row),
    .wr_lane   (wr_lane),
    .wr_data   (in_ch.rx_byte),
    .rd_en     (rd_en),
    .rd_row    (rd_row),
    .rd_data_r (rd_data_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      kind_r  <= emit.kind;
      index_r <= emit.index;
      word_r  <= (emit.kind == pfr_pkg::KIND_WORD) ? rd_data_r : 32'd0;
      last_r  <= emit.last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = kind_r;
  assign out_ch.param_index = index_r;
  assign out_ch.param_word  = word_r;
  assign out_ch.last        = last_r;

endmodule

`default_nettype wire
